FILE: hw/rtl/vwtm_pkg.sv
// Shared types and constants for the vibration window trip monitor.
// No dependencies; imported by every module of the block.
package vwtm_pkg;

  localparam int unsigned NUM_AXES = 3;
  localparam int unsigned LEVEL_W  = 18;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  typedef enum logic [2:0] {
    REG_ENABLE        = 3'd0,
    REG_SAMPLE_PERIOD = 3'd1,
    REG_WINDOW_LENGTH = 3'd2,
    REG_MOTION_LEVEL  = 3'd3,
    REG_WARNING_LEVEL = 3'd4,
    REG_TRIP_LEVEL    = 3'd5,
    REG_SHOCK_LEVEL   = 3'd6,
    REG_TRIP_HOLD_MS  = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_GOOD  = 2'd1,
    EV_CLOSE = 2'd2,
    EV_LOSE  = 2'd3
  } ev_kind_e;

  typedef struct packed {
    ev_kind_e            kind;
    logic [TIME_W-1:0]   now_ms;
  } event_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               window_done;
    logic               in_motion;
    logic               warning;
    logic               tripped;
    logic               sensor_ok;
  } status_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] motion_level;
    logic [LEVEL_W-1:0] warning_level;
    logic [LEVEL_W-1:0] trip_level;
    logic [LEVEL_W-1:0] shock_level;
    logic [TIME_W-1:0]  trip_hold_ms;
  } thresh_t;

endpackage

FILE: hw/rtl/vwtm_lane.sv
// One axis lane: running min and max of the samples in the current window.
// Registers the peak-to-peak span when the window closes. Uses vwtm_pkg.
module vwtm_lane #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          take_i,
  input  logic                          close_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic        [SAMPLE_BITS-1:0] span_o
);
  import vwtm_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] SMax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMin = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] min_q, min_d, max_q, max_d;
  logic signed [SAMPLE_BITS-1:0] min_n, max_n;
  logic        [SAMPLE_BITS-1:0] span_q, span_d;

  always_comb begin
    min_n  = (sample_i < min_q) ? sample_i : min_q;
    max_n  = (sample_i > max_q) ? sample_i : max_q;
    span_d = SAMPLE_BITS'(max_n - min_n);
    min_d  = min_q;
    max_d  = max_q;
    if (take_i) begin
      if (close_i) begin
        min_d = SMax;
        max_d = SMin;
      end else begin
        min_d = min_n;
        max_d = max_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= SMax;
      max_q <= SMin;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && close_i) begin
      span_q <= span_d;
    end
  end

  assign span_o = span_q;

endmodule

FILE: hw/rtl/vwtm_merge.sv
// Merging stage: sums the lane spans into the level and keeps the flags,
// sustained-trip timer and latched trip. Uses vwtm_pkg.
module vwtm_merge #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        load_i,
  input  vwtm_pkg::event_t                            ev_i,
  input  logic [vwtm_pkg::NUM_AXES-1:0][SAMPLE_BITS-1:0] span_i,
  input  vwtm_pkg::thresh_t                           thresh_i,
  output vwtm_pkg::status_t                           status_o
);
  import vwtm_pkg::*;

  status_t           st_q, st_d;
  logic              hold_run_q, hold_run_d;
  logic [TIME_W-1:0] hold_start_q, hold_start_d;
  logic [LEVEL_W-1:0] sum;
  logic [TIME_W-1:0] held;

  always_comb begin
    sum  = LEVEL_W'(span_i[0]) + LEVEL_W'(span_i[1]) + LEVEL_W'(span_i[2]);
    held = ev_i.now_ms - hold_start_q;
  end

  always_comb begin
    st_d         = st_q;
    hold_run_d   = hold_run_q;
    hold_start_d = hold_start_q;
    if (load_i) begin
      st_d.window_done = 1'b0;
      case (ev_i.kind)
        EV_GOOD: begin
          st_d.sensor_ok = 1'b1;
        end
        EV_LOSE: begin
          st_d.sensor_ok = 1'b0;
          st_d.level     = '0;
        end
        EV_CLOSE: begin
          st_d.sensor_ok   = 1'b1;
          st_d.window_done = 1'b1;
          st_d.level       = sum;
          st_d.in_motion   = sum >= thresh_i.motion_level;
          st_d.warning     = sum >= thresh_i.warning_level;
          if (sum >= thresh_i.shock_level) begin
            st_d.tripped = 1'b1;
          end else if (sum >= thresh_i.trip_level) begin
            if (!hold_run_q) begin
              hold_run_d   = 1'b1;
              hold_start_d = ev_i.now_ms;
            end else if (held >= thresh_i.trip_hold_ms) begin
              st_d.tripped = 1'b1;
            end
          end else begin
            hold_run_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= '0;
      hold_run_q   <= 1'b0;
      hold_start_q <= '0;
    end else begin
      st_q         <= st_d;
      hold_run_q   <= hold_run_d;
      hold_start_q <= hold_start_d;
    end
  end

  assign status_o = st_q;

endmodule

FILE: hw/rtl/vibration_window_trip_monitor_core.sv
// Vibration window trip monitor, top level: configuration registers, poll
// gating, window counter, three axis lanes and the merging stage.
// An accepted poll word is registered in the poll stage, then loaded into the merging stage.
// Throughput: one word per cycle while the output is not stalled; the poll stage and the merging
// stage each hold one word, and the merging stage's registers are the output payload.
// Reset: asynchronous, active low; ev_q and the lane span registers are not reset, others take their documented values.
module vibration_window_trip_monitor_core #(
  parameter int unsigned SAMPLE_BITS       = 16,
  parameter int unsigned SENSOR_TIMEOUT_MS = 200
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vwtm_pkg::ADDR_W-1:0]   paddr,
  input  logic [vwtm_pkg::DATA_W-1:0]   pwdata,
  output logic [vwtm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [31:0]                   now_ms_i,
  input  logic                          read_ok_i,
  input  logic signed [15:0]            accel_x_i,
  input  logic signed [15:0]            accel_y_i,
  input  logic signed [15:0]            accel_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [17:0]                   vibration_level_o,
  output logic                          window_done_o,
  output logic                          in_motion_o,
  output logic                          warning_o,
  output logic                          tripped_o,
  output logic                          sensor_ok_o
);
  import vwtm_pkg::*;

  logic               enable_q;
  logic [15:0]        sample_period_q;
  logic [15:0]        window_length_q;
  thresh_t            thresh_q;
  logic               cfg_we;
  reg_idx_e           cfg_idx;

  logic               s1_valid_q, s1_valid_d;
  logic               out_valid_q, out_valid_d;
  logic               adv2, in_accept;
  event_t             ev_q, ev_d;

  logic [TIME_W-1:0]  last_poll_q, last_poll_d;
  logic [TIME_W-1:0]  last_good_q, last_good_d;
  logic [15:0]        count_q, count_d, count_inc;
  logic               take_poll, take_good, close, lose;
  logic [TIME_W-1:0]  since_poll, since_good;

  logic signed [NUM_AXES-1:0][SAMPLE_BITS-1:0] samp;
  logic [NUM_AXES-1:0][SAMPLE_BITS-1:0]        span;
  status_t            status;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q               <= 1'b0;
      sample_period_q        <= 16'd10;
      window_length_q        <= 16'd50;
      thresh_q.motion_level  <= '0;
      thresh_q.warning_level <= '0;
      thresh_q.trip_level    <= '0;
      thresh_q.shock_level   <= LEVEL_W'(196605);
      thresh_q.trip_hold_ms  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ENABLE:        enable_q               <= pwdata[0];
        REG_SAMPLE_PERIOD: sample_period_q        <= pwdata[15:0];
        REG_WINDOW_LENGTH: window_length_q        <= pwdata[15:0];
        REG_MOTION_LEVEL:  thresh_q.motion_level  <= pwdata[LEVEL_W-1:0];
        REG_WARNING_LEVEL: thresh_q.warning_level <= pwdata[LEVEL_W-1:0];
        REG_TRIP_LEVEL:    thresh_q.trip_level    <= pwdata[LEVEL_W-1:0];
        REG_SHOCK_LEVEL:   thresh_q.shock_level   <= pwdata[LEVEL_W-1:0];
        REG_TRIP_HOLD_MS:  thresh_q.trip_hold_ms  <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ENABLE:        prdata = DATA_W'(enable_q);
      REG_SAMPLE_PERIOD: prdata = DATA_W'(sample_period_q);
      REG_WINDOW_LENGTH: prdata = DATA_W'(window_length_q);
      REG_MOTION_LEVEL:  prdata = DATA_W'(thresh_q.motion_level);
      REG_WARNING_LEVEL: prdata = DATA_W'(thresh_q.warning_level);
      REG_TRIP_LEVEL:    prdata = DATA_W'(thresh_q.trip_level);
      REG_SHOCK_LEVEL:   prdata = DATA_W'(thresh_q.shock_level);
      REG_TRIP_HOLD_MS:  prdata = thresh_q.trip_hold_ms;
      default:           prdata = '0;
    endcase
  end

  // Handshake: poll stage feeds the merging stage, whose registers are the output word
  assign adv2        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_accept || (s1_valid_q && !adv2);
  assign out_valid_d = adv2 || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  // Poll gating and window count
  always_comb begin
    since_poll = now_ms_i - last_poll_q;
    since_good = now_ms_i - last_good_q;
    take_poll  = enable_q && (since_poll >= TIME_W'(sample_period_q));
    take_good  = in_accept && take_poll && read_ok_i;
    count_inc  = count_q + 16'd1;
    close      = count_inc >= window_length_q;
    lose       = !read_ok_i && (since_good > TIME_W'(SENSOR_TIMEOUT_MS));

    last_poll_d = last_poll_q;
    last_good_d = last_good_q;
    count_d     = count_q;
    if (in_accept && take_poll) begin
      last_poll_d = now_ms_i;
    end
    if (take_good) begin
      last_good_d = now_ms_i;
      count_d     = close ? 16'd0 : count_inc;
    end

    ev_d.now_ms = now_ms_i;
    if (!take_poll) begin
      ev_d.kind = EV_NONE;
    end else if (read_ok_i) begin
      ev_d.kind = close ? EV_CLOSE : EV_GOOD;
    end else begin
      ev_d.kind = lose ? EV_LOSE : EV_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_poll_q <= '0;
      last_good_q <= '0;
      count_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      last_poll_q <= last_poll_d;
      last_good_q <= last_good_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ev_q <= ev_d;
    end
  end

  // Axis lanes
  assign samp[0] = accel_x_i[SAMPLE_BITS-1:0];
  assign samp[1] = accel_y_i[SAMPLE_BITS-1:0];
  assign samp[2] = accel_z_i[SAMPLE_BITS-1:0];

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    vwtm_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .take_i  (take_good),
      .close_i (close),
      .sample_i(samp[g]),
      .span_o  (span[g])
    );
  end

  vwtm_merge #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv2),
    .ev_i    (ev_q),
    .span_i  (span),
    .thresh_i(thresh_q),
    .status_o(status)
  );

  assign vibration_level_o = status.level;
  assign window_done_o     = status.window_done;
  assign in_motion_o       = status.in_motion;
  assign warning_o         = status.warning;
  assign tripped_o         = status.tripped;
  assign sensor_ok_o       = status.sensor_ok;

endmodule

FILE: verif/tb.sv
// Testbench for vibration_window_trip_monitor_core: a directed table, then random phases, all checked
// word by word: typed table rows against their fixed words, the rest against a behavioural model in this file.
// Depends on hw/rtl/vwtm_pkg.sv and the core RTL; drives the APB port and both word channels.
module tb;
  import vwtm_pkg::*;

  localparam int unsigned TIMEOUT_MS = 200;
  localparam int          N_PHASES   = 8;
  localparam int          WATCHDOG   = 1000;
  localparam logic signed [15:0] S_MIN = 16'sh8000;
  localparam logic signed [15:0] S_MAX = 16'sh7FFF;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               read_ok;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } poll_t;

  typedef enum logic {ROW_POLL, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    reg_idx_e    idx;
    logic [31:0] data;
    poll_t       poll;
    bit          typed;
    status_t     want;
  } row_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [31:0]       now_ms_i = '0;
  logic              read_ok_i = 1'b0;
  logic signed [15:0] accel_x_i = '0, accel_y_i = '0, accel_z_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [17:0]       vibration_level_o;
  logic              window_done_o, in_motion_o, warning_o, tripped_o, sensor_ok_o;

  vibration_window_trip_monitor_core #(
    .SAMPLE_BITS      (16),
    .SENSOR_TIMEOUT_MS(TIMEOUT_MS)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .now_ms_i         (now_ms_i),
    .read_ok_i        (read_ok_i),
    .accel_x_i        (accel_x_i),
    .accel_y_i        (accel_y_i),
    .accel_z_i        (accel_z_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .vibration_level_o(vibration_level_o),
    .window_done_o    (window_done_o),
    .in_motion_o      (in_motion_o),
    .warning_o        (warning_o),
    .tripped_o        (tripped_o),
    .sensor_ok_o      (sensor_ok_o)
  );

  // monitor state as seen from the register file and the poll history
  logic        cfg_en = 1'b0;
  logic [15:0] cfg_period = 16'd10;
  logic [15:0] cfg_window = 16'd50;
  thresh_t     thr = '{motion_level: '0, warning_level: '0, trip_level: '0,
                       shock_level: 18'd196605, trip_hold_ms: '0};
  logic signed [15:0] ext_lo [3] = '{default: S_MAX};
  logic signed [15:0] ext_hi [3] = '{default: S_MIN};
  logic [15:0] win_cnt = '0;
  logic [17:0] lvl = '0;
  logic        motion_f = 0, warning_f = 0, trip_f = 0, sensor_f = 0, hold_on = 0;
  logic [31:0] hold_t0 = '0, last_poll_ms = '0, last_good_ms = '0;

  status_t status_q [$];
  row_t    plan [$];
  int      mismatches = 0, polls_sent = 0, windows_closed = 0, sensor_losses = 0;
  int      cfg_writes = 0;
  int      gap_pct = 15, stall_pct = 15, stall_left = 0, quiet = 0;
  logic [31:0] clock_ms = 32'd200000;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic status_t st(int level, int done, int mot, int warn, int trip, int sens);
    return '{level: 18'(level), window_done: 1'(done), in_motion: 1'(mot),
             warning: 1'(warn), tripped: 1'(trip), sensor_ok: 1'(sens)};
  endfunction

  function automatic void add_poll(logic [31:0] now, logic ok, logic signed [15:0] x,
                                   logic signed [15:0] y, logic signed [15:0] z,
                                   bit typed = 1'b0, status_t want = '0);
    row_t r;
    r.kind  = ROW_POLL;
    r.idx   = REG_ENABLE;
    r.data  = '0;
    r.poll  = '{now_ms: now, read_ok: ok, ax: x, ay: y, az: z};
    r.typed = typed;
    r.want  = want;
    plan.push_back(r);
  endfunction

  function automatic void add_cfg(reg_idx_e idx, logic [31:0] data);
    row_t r;
    r.kind  = ROW_CFG;
    r.idx   = idx;
    r.data  = data;
    r.poll  = '0;
    r.typed = 1'b0;
    r.want  = '0;
    plan.push_back(r);
  endfunction

  function automatic void store_reg(reg_idx_e idx, logic [31:0] v);
    case (idx)
      REG_ENABLE:        cfg_en = v[0];
      REG_SAMPLE_PERIOD: cfg_period = v[15:0];
      REG_WINDOW_LENGTH: cfg_window = v[15:0];
      REG_MOTION_LEVEL:  thr.motion_level = v[17:0];
      REG_WARNING_LEVEL: thr.warning_level = v[17:0];
      REG_TRIP_LEVEL:    thr.trip_level = v[17:0];
      REG_SHOCK_LEVEL:   thr.shock_level = v[17:0];
      REG_TRIP_HOLD_MS:  thr.trip_hold_ms = v;
      default: ;
    endcase
  endfunction

  task automatic monitor_poll(input poll_t p, output status_t r);
    logic signed [15:0] s [3];
    logic [15:0]        span;
    int                 sum;
    logic               done;
    s[0] = p.ax;
    s[1] = p.ay;
    s[2] = p.az;
    done = 1'b0;
    if (cfg_en && (p.now_ms - last_poll_ms) >= {16'd0, cfg_period}) begin
      last_poll_ms = p.now_ms;
      if (p.read_ok) begin
        sensor_f = 1'b1;
        last_good_ms = p.now_ms;
        for (int i = 0; i < 3; i++) begin
          if (s[i] < ext_lo[i]) ext_lo[i] = s[i];
          if (s[i] > ext_hi[i]) ext_hi[i] = s[i];
        end
        win_cnt = win_cnt + 16'd1;
        if (win_cnt >= cfg_window) begin
          sum = 0;
          for (int i = 0; i < 3; i++) begin
            span = ext_hi[i] - ext_lo[i];
            sum += span;
            ext_lo[i] = S_MAX;
            ext_hi[i] = S_MIN;
          end
          lvl = (sum > 32'h3FFFF) ? 18'h3FFFF : sum[17:0];
          win_cnt = '0;
          done = 1'b1;
          windows_closed++;
          motion_f  = lvl >= thr.motion_level;
          warning_f = lvl >= thr.warning_level;
          if (lvl >= thr.shock_level) begin
            trip_f = 1'b1;
          end else if (lvl >= thr.trip_level) begin
            if (!hold_on) begin
              hold_on = 1'b1;
              hold_t0 = p.now_ms;
            end else if (p.now_ms - hold_t0 >= thr.trip_hold_ms) begin
              trip_f = 1'b1;
            end
          end else begin
            hold_on = 1'b0;
          end
        end
      end else if (p.now_ms - last_good_ms > TIMEOUT_MS) begin
        if (sensor_f) sensor_losses++;
        sensor_f = 1'b0;
        lvl = '0;
      end
    end
    r = '{level: lvl, window_done: done, in_motion: motion_f, warning: warning_f,
          tripped: trip_f, sensor_ok: sensor_f};
  endtask

  task automatic send_poll(input poll_t p, input bit typed, input status_t want);
    status_t pred;
    int      gap;
    gap = ($urandom_range(99) < gap_pct) ? $urandom_range(19, 1) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    now_ms_i   <= p.now_ms;
    read_ok_i  <= p.read_ok;
    accel_x_i  <= p.ax;
    accel_y_i  <= p.ay;
    accel_z_i  <= p.az;
    do @(posedge clk_i); while (in_stall_o);
    monitor_poll(p, pred);
    status_q.push_back(typed ? want : pred);
    polls_sent++;
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    store_reg(idx, data);
    cfg_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] axis_value(int amp);
    int v;
    v = int'($urandom_range(2 * amp)) - amp;
    return v[15:0];
  endfunction

  function automatic logic [31:0] pick_level(int top);
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32'd0;
    if (r == 9) return 32'h3FFFF;
    return $urandom_range(top);
  endfunction

  task automatic run_phase(input int ph);
    int    n, amp, top, per, step, outage, fail_pct, r;
    bit    last;
    poll_t p;
    settle();
    last      = (ph == N_PHASES - 1);
    gap_pct   = last ? 0 : 15 * $urandom_range(2);
    stall_pct = last ? 0 : 15 * $urandom_range(2);
    case ($urandom_range(2))
      0:       amp = $urandom_range(300);
      1:       amp = 4000;
      default: amp = 32767;
    endcase
    top = (6 * amp > 196605) ? 196605 : 6 * amp;
    r = $urandom_range(9);
    per = (r == 0) ? 0 : (r == 9) ? 65535 : $urandom_range(20, 1);
    apb_write(REG_ENABLE, 32'(ph != 2));
    apb_write(REG_SAMPLE_PERIOD, per);
    r = $urandom_range(9);
    apb_write(REG_WINDOW_LENGTH, (r == 9) ? 65535 : (r == 8) ? 0 : $urandom_range(6, 1));
    apb_write(REG_MOTION_LEVEL, pick_level(top));
    apb_write(REG_WARNING_LEVEL, pick_level(top));
    apb_write(REG_TRIP_LEVEL, pick_level(top));
    // arm the latching trip only in the final phase
    if (last) begin
      apb_write(REG_SHOCK_LEVEL, $urandom_range(1) ? 32'h3FFFF : pick_level(top));
      apb_write(REG_TRIP_HOLD_MS, ($urandom_range(3) == 0) ? 0 : $urandom_range(400));
    end else begin
      apb_write(REG_SHOCK_LEVEL, 32'h3FFFF);
      apb_write(REG_TRIP_HOLD_MS, 32'hFFFF_FFFF);
    end
    n = (ph == 2) ? 12 : 102;
    outage = 0;
    fail_pct = $urandom_range(15);
    repeat (n) begin
      if ($urandom_range(99) < 8) begin
        p.now_ms  = $urandom;
        p.read_ok = 1'($urandom_range(1));
        p.ax      = 16'($urandom);
        p.ay      = 16'($urandom);
        p.az      = 16'($urandom);
      end else begin
        step = ($urandom_range(3) == 0) ? $urandom_range(per) : per + $urandom_range(30);
        if ($urandom_range(49) == 0) step += 1000;
        clock_ms += step;
        if (outage == 0 && $urandom_range(99) < 3) outage = $urandom_range(40, 5);
        if (outage != 0) begin
          p.read_ok = 1'b0;
          outage--;
        end else begin
          p.read_ok = ($urandom_range(99) >= fail_pct);
        end
        p.now_ms = clock_ms;
        p.ax     = axis_value(amp);
        p.ay     = axis_value(amp);
        p.az     = axis_value(amp);
      end
      send_poll(p, 1'b0, '0);
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    status_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (status_q.size() == 0) begin
        $error("status word with no poll outstanding");
        mismatches++;
      end else begin
        want = status_q.pop_front();
        check_field("vibration_level", 32'(want.level), 32'(vibration_level_o));
        check_field("window_done", 32'(want.window_done), 32'(window_done_o));
        check_field("in_motion", 32'(want.in_motion), 32'(in_motion_o));
        check_field("warning", 32'(want.warning), 32'(warning_o));
        check_field("tripped", 32'(want.tripped), 32'(tripped_o));
        check_field("sensor_ok", 32'(want.sensor_ok), 32'(sensor_ok_o));
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(18);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
    else quiet++;
    if (quiet == WATCHDOG) begin
      $error("no word moved for %0d cycles", WATCHDOG);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    bit pending;
    add_poll(32'd0, 1'b1, S_MIN, S_MAX, 16'sd0, 1'b1, st(0, 0, 0, 0, 0, 0));
    add_poll(32'hFFFF_FFFF, 1'b0, S_MAX, S_MIN, 16'sd0, 1'b1, st(0, 0, 0, 0, 0, 0));
    add_cfg(REG_ENABLE, 32'd1);
    add_cfg(REG_SAMPLE_PERIOD, 32'd0);
    add_cfg(REG_WINDOW_LENGTH, 32'd1);
    add_cfg(REG_MOTION_LEVEL, 32'h3FFFF);
    add_cfg(REG_WARNING_LEVEL, 32'd100000);
    add_cfg(REG_TRIP_LEVEL, 32'h3FFFF);
    add_cfg(REG_SHOCK_LEVEL, 32'h3FFFF);
    add_cfg(REG_TRIP_HOLD_MS, 32'hFFFF_FFFF);
    add_poll(32'd5, 1'b1, S_MIN, S_MIN, S_MIN, 1'b1, st(0, 1, 0, 0, 0, 1));
    add_cfg(REG_WINDOW_LENGTH, 32'd2);
    add_poll(32'd10, 1'b1, S_MIN, S_MIN, S_MIN, 1'b1, st(0, 0, 0, 0, 0, 1));
    add_poll(32'd20, 1'b1, S_MAX, S_MAX, S_MAX, 1'b1, st(196605, 1, 0, 1, 0, 1));
    add_poll(32'd100, 1'b0, 16'sd7, -16'sd7, 16'sd0);
    add_poll(32'd220, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b1, st(196605, 0, 0, 1, 0, 1));
    add_poll(32'd221, 1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b1, st(0, 0, 0, 1, 0, 0));
    add_poll(32'd222, 1'b1, 16'sd1, -16'sd1, 16'sd0);
    add_cfg(REG_SAMPLE_PERIOD, 32'd65535);
    add_poll(32'd300, 1'b1, S_MAX, S_MAX, S_MAX);
    add_poll(32'hFFFF_FFFF, 1'b1, S_MIN, 16'sd0, S_MAX);
    add_poll(32'h0000_FFFE, 1'b1, 16'sd5, 16'sd0, 16'sd0);
    add_poll(32'h0000_FFFF, 1'b1, S_MIN, S_MIN, S_MIN);
    add_cfg(REG_SAMPLE_PERIOD, 32'd10);
    add_cfg(REG_WINDOW_LENGTH, 32'd0);
    add_cfg(REG_MOTION_LEVEL, 32'd0);
    add_cfg(REG_WARNING_LEVEL, 32'd0);
    add_cfg(REG_TRIP_LEVEL, 32'd1000);
    add_poll(32'd131072, 1'b1, S_MIN, 16'sd0, 16'sd0);
    add_cfg(REG_WINDOW_LENGTH, 32'd3);
    add_poll(32'd131082, 1'b1, -16'sd1000, 16'sd0, 16'sd0);
    add_poll(32'd131092, 1'b1, 16'sd1000, 16'sd0, 16'sd0);
    add_poll(32'd131102, 1'b1, 16'sd0, 16'sd0, 16'sd0);
    add_poll(32'd131112, 1'b1, 16'sd0, -16'sd800, 16'sd0);
    add_poll(32'd131122, 1'b1, 16'sd0, 16'sd800, 16'sd0);
    add_poll(32'd131132, 1'b1, 16'sd0, 16'sd0, 16'sd0);
    add_poll(32'd131142, 1'b1, 16'sd0, 16'sd0, 16'sd0);
    add_poll(32'd131152, 1'b1, 16'sd0, 16'sd0, 16'sd0);
    add_poll(32'd131162, 1'b1, 16'sd0, 16'sd0, 16'sd0);
    add_poll(32'd131167, 1'b1, S_MAX, S_MIN, S_MAX);

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    pending = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        if (pending) settle();
        pending = 1'b0;
        apb_write(plan[i].idx, plan[i].data);
      end else begin
        send_poll(plan[i].poll, plan[i].typed, plan[i].want);
        pending = 1'b1;
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) run_phase(ph);

    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Checked %0d polls over %0d register writes: %0d windows closed, %0d sensor losses.",
             polls_sent, cfg_writes, windows_closed, sensor_losses);
    $display("Trip latched by end of run: %0d; mismatches: %0d.", trip_f, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/vwtm_pkg.sv
hw/rtl/vwtm_lane.sv
hw/rtl/vwtm_merge.sv
hw/rtl/vibration_window_trip_monitor_core.sv
verif/tb.sv
